// ===== sv/sgbh_pkg.sv =====
// Package for the spatial grid bin hash: slot layout and shared constants.
`default_nettype none
package sgbh_pkg;

  localparam int unsigned DefBuckets = 256;
  localparam int unsigned DefWays    = 4;

  localparam int unsigned CoordW = 24;
  localparam int unsigned IbwW   = 24;
  localparam int unsigned IdW    = 12;
  localparam int unsigned BinW   = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned MulW   = 25;
  localparam int unsigned ProdW  = 2 * MulW;

  localparam logic [MulW-1:0] HashMulI = MulW'(378551);
  localparam logic [MulW-1:0] HashMulJ = MulW'(63689);

  // command codes
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  // result status codes
  localparam logic [1:0] StAdded = 2'd0;
  localparam logic [1:0] StNew   = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;
  localparam logic [1:0] StQuery = 2'd3;

  // One bin slot of a bucket row.
  typedef struct packed {
    logic                     valid;
    logic [BinW-1:0]          key_i;
    logic [BinW-1:0]          key_j;
    logic [CountW-1:0]        count;
    logic [IdW-1:0]           first_id;
    logic signed [CoordW-1:0] first_x;
    logic signed [CoordW-1:0] first_y;
  } slot_t;

endpackage
`default_nettype wire

// ===== sv/sgbh_mul.sv =====
// Shared signed 25x25 multiplier with registered product.
`default_nettype none
module sgbh_mul (
  input  logic                               clk_i,
  input  logic signed [sgbh_pkg::MulW-1:0]   a_i,
  input  logic signed [sgbh_pkg::MulW-1:0]   b_i,
  output logic signed [sgbh_pkg::ProdW-1:0]  prod_o
);
  import sgbh_pkg::*;

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== sv/sgbh_mod.sv =====
// Iterative 32-bit modulo by the bucket count, eight bits per cycle.
`default_nettype none
module sgbh_mod #(
  parameter int unsigned BUCKETS = sgbh_pkg::DefBuckets,
  localparam int unsigned BW = $clog2(BUCKETS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   value_i,
  output logic          done_o,
  output logic [BW-1:0] rem_o
);
  import sgbh_pkg::*;

  localparam int unsigned RW = BW + 1;
  localparam logic [RW-1:0] BRem = RW'(BUCKETS);

  logic [31:0]   sh_q;
  logic [BW-1:0] r_q, r_d;
  logic [1:0]    cnt_q;
  logic          busy_q, done_q;

  always_comb begin
    logic [RW-1:0] t;
    logic [BW-1:0] r;
    r = r_q;
    t = '0;
    for (int k = 0; k < 8; k++) begin
      t = {r, sh_q[31-k]};
      if (t >= BRem) t = t - BRem;
      r = t[BW-1:0];
    end
    r_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      r_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sh_q   <= value_i;
        r_q    <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        sh_q  <= {sh_q[23:0], 8'h00};
        r_q   <= r_d;
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule
`default_nettype wire

// ===== sv/sgbh_store.sv =====
// Bucket memory: one row of WAYS slots per bucket, cleared by a sweep after reset.
`default_nettype none
module sgbh_store #(
  parameter int unsigned BUCKETS = sgbh_pkg::DefBuckets,
  parameter int unsigned WAYS    = sgbh_pkg::DefWays,
  localparam int unsigned AW = $clog2(BUCKETS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            rd_en_i,
  input  logic [AW-1:0]                   rd_addr_i,
  output sgbh_pkg::slot_t [WAYS-1:0]      rd_row_o,
  input  logic                            wr_en_i,
  input  logic [AW-1:0]                   wr_addr_i,
  input  sgbh_pkg::slot_t [WAYS-1:0]      wr_row_i,
  output logic                            ready_o
);
  import sgbh_pkg::*;

  slot_t [WAYS-1:0] mem_q [BUCKETS];
  slot_t [WAYS-1:0] rd_q;
  logic             clearing_q;
  logic [AW-1:0]    clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(BUCKETS - 1)) clearing_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) rd_q <= mem_q[rd_addr_i];
  end

  assign rd_row_o = rd_q;
  assign ready_o  = !clearing_q;

endmodule
`default_nettype wire

// ===== sv/spatial_grid_bin_hash.sv =====
// Top level of the spatial grid bin hash: sequencer around shared multiplier, modulo and store.
//
//  channel   dir   handshake                   payload
//  cfg       in    cfg_valid_i / cfg_ready_o   cfg_data_i: inv_bin_width
//  s_axis    in    s_axis_tvalid / tready      tuser: command; tdata: x, y, point_id
//  m_axis    out   m_axis_tvalid / tready      tuser: status; tdata: found, count, id, neigh
//
// An insert makes one bin probe from its accepting beat to its result beat, a query up to nine:
// each probe runs two hash products through the one multiplier, the iterative modulo and one
// bucket row read. Each item ends with a return to idle, where the next beat may be taken.
// Neighbors outside the index range are skipped without a hash or bucket row read.
// After reset the store is swept one bucket row per cycle before the first
// beat is taken. One item is in work at a time; a finished result waits in the output
// register while the next beat may already be accepted.
`default_nettype none
module spatial_grid_bin_hash #(
  parameter int unsigned BUCKETS = sgbh_pkg::DefBuckets,
  parameter int unsigned WAYS    = sgbh_pkg::DefWays
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_coord[23:0], y_coord[47:24], point_id[59:48]
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // bin_found[0], bin_point_count[8:1],
                                      // first_point_id[20:9], neighbor_bins[24:21]
  output logic [1:0]  m_axis_tuser    // status
);
  import sgbh_pkg::*;

  localparam int unsigned AW = $clog2(BUCKETS);
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam logic [3:0] LastProbe = 4'd8;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL_X, S_MUL_Y, S_BIN, S_PROBE,
    S_HASH_A, S_HASH_B, S_HASH_S, S_MOD, S_EVAL, S_FINISH
  } state_e;

  state_e state_q;

  logic [IbwW-1:0]          ibw_q;
  logic                     cmd_q;
  logic signed [CoordW-1:0] x_q, y_q;
  logic [IdW-1:0]           id_q;
  logic [BinW-1:0]          bi_q, bj_q, ni_q, nj_q;
  logic [3:0]               probe_q;
  logic [31:0]              ph_q;
  logic [AW-1:0]            bucket_q;
  logic [1:0]               res_status_q;
  logic                     res_found_q;
  logic [CountW-1:0]        res_count_q;
  logic [IdW-1:0]           res_first_q;
  logic [3:0]               res_neigh_q;
  logic                     m_valid_q;
  logic [1:0]               m_user_q;
  logic [31:0]              m_data_q;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  prod;
  logic                     mod_start, mod_done;
  logic [31:0]              mod_value;
  logic [AW-1:0]            mod_rem;
  logic                     rd_en, wr_en, store_ready;
  slot_t [WAYS-1:0]         rd_row, wr_row;

  // probe 0 is the own bin, probes 1..8 the neighbors
  logic signed [1:0] di, dj;
  always_comb begin
    case (probe_q)
      4'd1:    begin di = -2'sd1; dj = -2'sd1; end
      4'd2:    begin di = -2'sd1; dj =  2'sd0; end
      4'd3:    begin di = -2'sd1; dj =  2'sd1; end
      4'd4:    begin di =  2'sd0; dj = -2'sd1; end
      4'd5:    begin di =  2'sd0; dj =  2'sd1; end
      4'd6:    begin di =  2'sd1; dj = -2'sd1; end
      4'd7:    begin di =  2'sd1; dj =  2'sd0; end
      4'd8:    begin di =  2'sd1; dj =  2'sd1; end
      default: begin di =  2'sd0; dj =  2'sd0; end
    endcase
  end

  logic [BinW:0] ni_ext, nj_ext;
  logic          nb_out;
  assign ni_ext = {1'b0, bi_q} + {{(BinW - 1){di[1]}}, di};
  assign nj_ext = {1'b0, bj_q} + {{(BinW - 1){dj[1]}}, dj};
  assign nb_out = ni_ext[BinW] | nj_ext[BinW];

  // biased bin index back to signed for the hash
  logic [BinW-1:0] hi_s, hj_s;
  assign hi_s = ni_q ^ 16'h8000;
  assign hj_s = nj_q ^ 16'h8000;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_X:  begin mul_a = MulW'(x_q); mul_b = {1'b0, ibw_q}; end
      S_MUL_Y:  begin mul_a = MulW'(y_q); mul_b = {1'b0, ibw_q}; end
      S_HASH_A: begin mul_a = MulW'($signed(hi_s)); mul_b = HashMulI; end
      S_HASH_B: begin mul_a = MulW'($signed(hj_s)); mul_b = HashMulJ; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  logic [31:0] hsum;
  assign hsum      = ph_q + prod[31:0];
  assign mod_value = hsum[31] ? (32'd0 - hsum) : hsum;
  assign mod_start = (state_q == S_HASH_S);
  assign rd_en     = (state_q == S_MOD) && mod_done;

  // bucket row compare: lowest matching way, lowest free way
  logic          hit, free;
  logic [WW-1:0] hit_w, free_w;
  always_comb begin
    hit = 1'b0;
    free = 1'b0;
    hit_w = '0;
    free_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && rd_row[w].key_i == ni_q && rd_row[w].key_j == nj_q) begin
        hit = 1'b1;
        hit_w = WW'(w);
      end
      if (!rd_row[w].valid) begin
        free = 1'b1;
        free_w = WW'(w);
      end
    end
  end

  slot_t hit_slot, upd_slot, new_slot;
  always_comb begin
    hit_slot = rd_row[hit_w];
    upd_slot = hit_slot;
    if (hit_slot.count != 8'hFF) upd_slot.count = hit_slot.count + 8'd1;
    if (x_q < hit_slot.first_x || (x_q == hit_slot.first_x && y_q < hit_slot.first_y)) begin
      upd_slot.first_id = id_q;
      upd_slot.first_x  = x_q;
      upd_slot.first_y  = y_q;
    end
    new_slot = '{valid: 1'b1, key_i: ni_q, key_j: nj_q, count: 8'd1,
                 first_id: id_q, first_x: x_q, first_y: y_q};
    wr_row = rd_row;
    if (hit) wr_row[hit_w] = upd_slot;
    else     wr_row[free_w] = new_slot;
  end

  assign wr_en = (state_q == S_EVAL) && (cmd_q == CmdInsert) && (hit || free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ibw_q <= IbwW'(65536);
    end else if (cfg_valid_i) begin
      ibw_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cmd_q        <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      id_q         <= '0;
      bi_q         <= '0;
      bj_q         <= '0;
      ni_q         <= '0;
      nj_q         <= '0;
      probe_q      <= '0;
      ph_q         <= '0;
      bucket_q     <= '0;
      res_status_q <= StAdded;
      res_found_q  <= 1'b0;
      res_count_q  <= '0;
      res_first_q  <= '0;
      res_neigh_q  <= '0;
      m_valid_q    <= 1'b0;
      m_user_q     <= '0;
      m_data_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_FINISH) m_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          if (store_ready) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q   <= s_axis_tuser;
            x_q     <= s_axis_tdata[23:0];
            y_q     <= s_axis_tdata[47:24];
            id_q    <= s_axis_tdata[59:48];
            state_q <= S_MUL_X;
          end
        end
        S_MUL_X: state_q <= S_MUL_Y;
        S_MUL_Y: begin
          bi_q    <= {~prod[47], prod[46:32]};
          state_q <= S_BIN;
        end
        S_BIN: begin
          bj_q        <= {~prod[47], prod[46:32]};
          probe_q     <= '0;
          res_found_q <= 1'b0;
          res_count_q <= '0;
          res_first_q <= '0;
          res_neigh_q <= '0;
          state_q     <= S_PROBE;
        end
        S_PROBE: begin
          if (nb_out) begin
            if (probe_q == LastProbe) state_q <= S_FINISH;
            probe_q <= probe_q + 4'd1;
          end else begin
            ni_q    <= ni_ext[BinW-1:0];
            nj_q    <= nj_ext[BinW-1:0];
            state_q <= S_HASH_A;
          end
        end
        S_HASH_A: state_q <= S_HASH_B;
        S_HASH_B: begin
          ph_q    <= prod[31:0];
          state_q <= S_HASH_S;
        end
        S_HASH_S: state_q <= S_MOD;
        S_MOD: begin
          if (mod_done) begin
            bucket_q <= mod_rem;
            state_q  <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (cmd_q == CmdInsert) begin
            if (hit) begin
              res_status_q <= StAdded;
              res_count_q  <= upd_slot.count;
              res_first_q  <= upd_slot.first_id;
            end else if (free) begin
              res_status_q <= StNew;
              res_count_q  <= 8'd1;
              res_first_q  <= id_q;
            end else begin
              res_status_q <= StFull;
            end
            state_q <= S_FINISH;
          end else begin
            res_status_q <= StQuery;
            if (probe_q == 4'd0) begin
              res_found_q <= hit;
              if (hit) begin
                res_count_q <= hit_slot.count;
                res_first_q <= hit_slot.first_id;
              end
            end else if (hit) begin
              res_neigh_q <= res_neigh_q + 4'd1;
            end
            if (probe_q == LastProbe) state_q <= S_FINISH;
            else                      state_q <= S_PROBE;
            probe_q <= probe_q + 4'd1;
          end
        end
        S_FINISH: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_status_q;
            m_data_q  <= {7'd0, res_neigh_q, res_first_q, res_count_q, res_found_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  sgbh_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  sgbh_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (mod_value),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  sgbh_store #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (mod_rem),
    .rd_row_o  (rd_row),
    .wr_en_i   (wr_en),
    .wr_addr_i (bucket_q),
    .wr_row_i  (wr_row),
    .ready_o   (store_ready)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> store_ready)
    else $error("beat taken during store clear");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat taken while busy");

  a_mod_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("modulo result outside wait state");

  a_neigh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[24:21] <= 4'd8))
    else $error("neighbor count above eight");

endmodule
`default_nettype wire
